// ----- hdl/zmss_pkg.sv -----
// Shared types and constants for the zero-marked slot set.
`default_nettype none

package zmss_pkg;

    localparam int SLOT_COUNT_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int REQ_VALUE_W     = 32;
    localparam int RSP_SLOT_W      = 6;

    typedef enum logic [1:0] {
        REQ_FIND   = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_REMOVED    = 3'd2,
        ST_MISS_EMPTY = 3'd3,
        ST_MISS_FULL  = 3'd4
    } status_t;

    typedef enum logic {
        SCAN_IDLE = 1'b0,
        SCAN_RUN  = 1'b1
    } scan_state_t;

    typedef struct packed {
        req_type_t              req_type;
        logic [REQ_VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [RSP_SLOT_W-1:0] slot;
    } rsp_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic advance;
        logic write;
        logic clear;
    } cell_cmd_t;

    // Summary of the chain seen by the controller.
    typedef struct packed {
        logic stop;
        logic hit;
        logic tail;
    } chain_stat_t;

endpackage

`default_nettype wire

// ----- hdl/zero_marked_slot_set.sv -----
// Top level of the zero-marked slot set: request control and response register.
//
//  channel | signals                       | payload
//  --------+-------------------------------+-----------------------------
//  request | req_valid, req_ready, req     | req_type, value
//  response| rsp_valid, rsp_ready, rsp     | status, slot
//
// A request scans the chain from slot 0 up to the slot that ends the scan, or until
// the scan runs off the end: the scan token moves one cell per cycle down the chain.
// One request is in flight at a time; the next is accepted once the previous
// response has been loaded, even while that response still waits to be taken.
// Reset empties every slot at once; no clearing pass is needed.
// A stalled response holds the finished scan in place until the register frees.
`default_nettype none

module zero_marked_slot_set
    import zmss_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int POS_W = $clog2(SLOT_COUNT + 1);

    scan_state_t            state_reg;
    scan_state_t            state_next;
    req_type_t              type_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   end_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;

    cell_cmd_t              cmd;
    chain_stat_t            stat;
    logic                   start;
    logic                   finish;
    logic                   rsp_free;
    logic                   load;
    logic [RSP_SLOT_W-1:0]  pos_slot;

    zmss_chain #(
        .SLOT_COUNT  (SLOT_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .value (value_reg),
        .start (start),
        .stat  (stat)
    );

    assign finish   = stat.stop | end_reg;
    assign rsp_free = !rsp_valid_reg | rsp_ready;
    assign pos_slot = RSP_SLOT_W'(pos_reg);

    assign req_ready = (state_reg == SCAN_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        start           = 1'b0;
        load            = 1'b0;
        cmd.advance     = 1'b1;
        cmd.write       = 1'b0;
        cmd.clear       = 1'b0;
        rsp_next.status = ST_MISS_FULL;
        rsp_next.slot   = '0;

        // Outcome of the scan; only used when the scan has finished.
        if (!end_reg)
        begin
            if (stat.hit)
            begin
                case (type_reg)
                    REQ_FIND, REQ_ADD:
                    begin
                        rsp_next.status = ST_HIT;
                        rsp_next.slot   = pos_slot;
                    end
                    REQ_REMOVE:
                    begin
                        rsp_next.status = ST_REMOVED;
                        rsp_next.slot   = pos_slot;
                    end
                    default:
                    begin
                        rsp_next.status = ST_MISS_FULL;
                    end
                endcase
            end
            else
            begin
                case (type_reg)
                    REQ_FIND:
                    begin
                        rsp_next.status = ST_MISS_EMPTY;
                        rsp_next.slot   = pos_slot;
                    end
                    REQ_ADD:
                    begin
                        rsp_next.status = ST_INSERTED;
                        rsp_next.slot   = pos_slot;
                    end
                    default:
                    begin
                        rsp_next.status = ST_MISS_FULL;
                    end
                endcase
            end
        end

        unique case (state_reg)
            SCAN_IDLE:
            begin
                if (req_valid)
                begin
                    start      = 1'b1;
                    state_next = SCAN_RUN;
                end
            end
            SCAN_RUN:
            begin
                if (finish)
                begin
                    if (rsp_free)
                    begin
                        load       = 1'b1;
                        state_next = SCAN_IDLE;
                        cmd.write  = !end_reg && !stat.hit && (type_reg == REQ_ADD);
                        cmd.clear  = !end_reg && stat.hit && (type_reg == REQ_REMOVE);
                    end
                    else
                    begin
                        cmd.advance = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = SCAN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SCAN_IDLE;
            pos_reg       <= '0;
            end_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                pos_reg <= '0;
                end_reg <= 1'b0;
            end
            else if (state_reg == SCAN_RUN && !finish)
            begin
                pos_reg <= pos_reg + POS_W'(1);
                if (stat.tail)
                begin
                    end_reg <= 1'b1;
                end
            end

            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            type_reg  <= req.req_type;
            value_reg <= VALUE_WIDTH'(req.value);
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN_IDLE) |-> !stat.stop && !stat.tail)
        else $error("scan token present while the controller is idle");

    a_end_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg |-> !stat.stop)
        else $error("a cell stopped a scan that already ran off the end");

    a_pos_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN_RUN && !finish) |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("slot position did not follow the scan token");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> rsp_valid && state_reg == SCAN_IDLE)
        else $error("finished request did not produce a response");

endmodule

`default_nettype wire

// ----- hdl/zmss_cell.sv -----
// One slot of the set, with the scan token that walks through the chain.
`default_nettype none

module zmss_cell
    import zmss_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cell_cmd_t              cmd,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic                   tok_in,
    output logic                        tok,
    output logic                        pass,
    output logic                        stop,
    output logic                        hit
);

    logic [VALUE_WIDTH-1:0] slot_reg;
    logic [VALUE_WIDTH-1:0] slot_next;
    logic                   tok_reg;
    logic                   tok_next;
    logic                   empty;
    logic                   match;

    assign empty = (slot_reg == '0);
    assign match = (slot_reg == value);

    // The scan ends at the first empty slot or at a match, whichever comes first.
    assign stop = tok_reg & (empty | match);
    assign hit  = tok_reg & !empty & match;
    assign pass = tok_reg & !empty & !match;
    assign tok  = tok_reg;

    always_comb
    begin
        tok_next  = cmd.advance ? tok_in : tok_reg;
        slot_next = slot_reg;
        if (tok_reg && cmd.write && empty)
        begin
            slot_next = value;
        end
        else if (tok_reg && cmd.clear && match && !empty)
        begin
            slot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            tok_reg  <= tok_next;
            slot_reg <= slot_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/zmss_chain.sv -----
// Row of slot cells linked by the scan token.
`default_nettype none

module zmss_chain
    import zmss_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cell_cmd_t              cmd,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic                   start,
    output chain_stat_t                 stat
);

    logic [SLOT_COUNT:0]   link;
    logic [SLOT_COUNT-1:0] tok_vec;
    logic [SLOT_COUNT-1:0] stop_vec;
    logic [SLOT_COUNT-1:0] hit_vec;

    assign link[0] = start;

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        zmss_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd),
            .value  (value),
            .tok_in (link[i]),
            .tok    (tok_vec[i]),
            .pass   (link[i+1]),
            .stop   (stop_vec[i]),
            .hit    (hit_vec[i])
        );
    end

    assign stat.stop = |stop_vec;
    assign stat.hit  = |hit_vec;
    assign stat.tail = link[SLOT_COUNT];

    a_token_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one scan token in the chain");

    a_hit_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        stat.hit |-> stat.stop)
        else $error("hit reported without the scan stopping");

    a_tail_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
        stat.tail |-> !stat.stop)
        else $error("token left the chain while a cell stopped it");

endmodule

`default_nettype wire
